[design/ppm_stream_decoder_unit_defines.svh]
// assertion macros for the ppm stream decoder
`ifndef PPM_STREAM_DECODER_UNIT_DEFINES_SVH
`define PPM_STREAM_DECODER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PSD_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define PSD_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[design/psd_pkg.sv]
`default_nettype none
package psd_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_MAGIC    = 3'd0;
    localparam logic [2:0] ERR_NUMBER   = 3'd1;
    localparam logic [2:0] ERR_SIZE     = 3'd2;
    localparam logic [2:0] ERR_MAXVAL   = 3'd3;
    localparam logic [2:0] ERR_TOOLARGE = 3'd4;
    localparam logic [2:0] ERR_TRUNC    = 3'd5;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_0    = 8'h30;

    localparam logic [16:0] ACC_SAT  = 17'd65536;
    localparam logic [14:0] SIDE_CAP = 15'd32767;

    // result word, fields as on the output port
    typedef struct packed {
        logic [2:0]  error_code;
        logic        last_pixel;
        logic [14:0] height_out;
        logic [14:0] width_out;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [1:0]  result_kind;
    } t_result;

    // divider request
    typedef struct packed {
        logic        start;
        logic [15:0] value;
        logic [15:0] maxval;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
    } t_div_rsp;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd11 ||
               c == 8'd12 || c == 8'd13;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

endpackage
`default_nettype wire

[design/psd_scaler.sv]
`default_nettype none
// scales v to (v*255 + m/2) / m saturated at 255, restoring division,
// one quotient bit per cycle
module psd_scaler (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire psd_pkg::t_div_req i_req,
    output psd_pkg::t_div_rsp      o_rsp
);
    import psd_pkg::*;

    logic [24:0] r_num, n_num;
    logic [15:0] r_den, n_den;
    logic [16:0] r_rem, n_rem;
    logic [8:0]  r_quo, n_quo;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [16:0] w_trial;
    logic [16:0] w_sh;

    // partial remainder shifted in one numerator bit per cycle
    assign w_sh    = {r_rem[15:0], r_num[24]};
    assign w_trial = w_sh - {1'b0, r_den};

    always_comb begin
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_den  = (i_req.maxval == 16'd0) ? 16'd1 : i_req.maxval;
            n_num  = ({1'b0, i_req.value, 8'd0} - {9'd0, i_req.value})
                     + {10'd0, n_den[15:1]};
            n_rem  = 17'd0;
            n_quo  = 9'd0;
            n_cnt  = 5'd25;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[23:0], 1'b0};
            if (!w_trial[16]) begin
                n_rem = w_trial;
                n_quo = {r_quo[7:0], 1'b1} | {r_quo[8], 8'd0};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[7:0], 1'b0} | {r_quo[8], 8'd0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    // bit 8 is sticky: any quotient bit above 7 saturates
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo[8] ? 8'hff : r_quo[7:0];
endmodule
`default_nettype wire

[design/ppm_stream_decoder_unit.sv]
`default_nettype none
// PPM decoder: one file byte per input word (tuser marks end of stream,
// which carries no byte). Every sample goes through a bit-serial divider,
// and no input byte is taken while it divides; one result word per header,
// pixel or error, held in an output register until taken.
`include "ppm_stream_decoder_unit_defines.svh"
module ppm_stream_decoder_unit #(
    parameter int MAX_SIDE         = 32767,
    parameter int MAX_SAMPLE_LIMIT = 65535
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // data_byte
    input  wire logic       s_axis_tuser,   // end_of_stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    // result_kind, red, green, blue, width_out, height_out, last_pixel,
    // error_code, 4 zero bits
    output logic [63:0]     m_axis_tdata
);
    import psd_pkg::*;

    localparam logic [16:0] SIDE_LIM = 17'(MAX_SIDE);
    localparam logic [16:0] SAMP_LIM = 17'(MAX_SAMPLE_LIMIT);

    typedef enum logic [13:0] {
        PH_SEEK    = 14'b00000000000001,
        PH_MAGIC   = 14'b00000000000010,
        PH_SKIP_W  = 14'b00000000000100,
        PH_NUM_W   = 14'b00000000001000,
        PH_SKIP_H  = 14'b00000000010000,
        PH_NUM_H   = 14'b00000000100000,
        PH_SKIP_M  = 14'b00000001000000,
        PH_NUM_M   = 14'b00000010000000,
        PH_BIN_HI  = 14'b00000100000000,
        PH_BIN_LO  = 14'b00001000000000,
        PH_TXT_SKP = 14'b00010000000000,
        PH_TXT_NUM = 14'b00100000000000,
        PH_DONE    = 14'b01000000000000,
        PH_ERR     = 14'b10000000000000
    } t_phase;

    t_phase      r_ph, n_ph;
    logic        r_ascii, n_ascii;
    logic        r_cmt, n_cmt;
    logic [16:0] r_acc, n_acc;
    logic [14:0] r_w, n_w, r_h, n_h, r_col, n_col, r_row, n_row;
    logic [15:0] r_max, n_max;
    logic [1:0]  r_ci, n_ci;
    logic [7:0]  r_hi, n_hi, r_red, n_red, r_grn, n_grn;
    logic        r_busy, n_busy;      // waiting on the divider
    logic        r_eos, n_eos;        // sample came from end of stream
    logic        r_ov, n_ov;
    t_result     r_out, n_out;
    t_div_req    w_req;
    t_div_rsp    w_rsp;
    logic        w_acc_in, w_out_free;
    logic [7:0]  c;
    logic [20:0] w_mul;
    logic        w_lastpos;
    logic [15:0] w_samp;

    psd_scaler u_scaler (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_out_free    = !r_ov || m_axis_tready;
    assign s_axis_tready = !r_busy && w_out_free;
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'b0000, r_out};
    assign c             = s_axis_tdata;
    assign w_mul = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {13'd0, c - CH_0};
    assign w_lastpos = ({1'b0, r_col} + 16'd1 >= {1'b0, r_w}) &&
                       ({1'b0, r_row} + 16'd1 >= {1'b0, r_h});
    // a saturated number scales to 255 just as 65535 does
    assign w_samp = (r_ph == PH_BIN_LO) ? {r_hi, c} :
                    (r_ph == PH_BIN_HI) ? {8'd0, c} :
                    r_acc[16] ? 16'hffff : r_acc[15:0];

    always_comb begin
        n_ph = r_ph; n_ascii = r_ascii; n_cmt = r_cmt; n_acc = r_acc;
        n_w = r_w; n_h = r_h; n_max = r_max; n_col = r_col; n_row = r_row;
        n_ci = r_ci; n_hi = r_hi; n_red = r_red; n_grn = r_grn;
        n_busy = r_busy; n_eos = r_eos; n_out = r_out;
        n_ov = r_ov && !m_axis_tready;
        w_req = '0;
        w_req.maxval = r_max;
        w_req.value  = w_samp;

        if (r_busy && w_rsp.done) begin
            n_busy = 1'b0;
            unique case (r_ci)
                2'd0: begin n_red = w_rsp.quot; n_ci = 2'd1; end
                2'd1: begin n_grn = w_rsp.quot; n_ci = 2'd2; end
                default: begin
                    n_ci = 2'd0;
                    n_out = '0;
                    n_out.result_kind = KIND_PIXEL;
                    n_out.red = r_red; n_out.green = r_grn; n_out.blue = w_rsp.quot;
                    n_out.last_pixel = w_lastpos;
                    n_ov = 1'b1;
                    if ({1'b0, r_col} + 16'd1 >= {1'b0, r_w}) begin
                        n_col = '0; n_row = r_row + 15'd1;
                    end else n_col = r_col + 15'd1;
                    if (w_lastpos) n_ph = PH_DONE;
                end
            endcase
            if (r_eos) begin
                n_eos = 1'b0;
                n_ph = PH_SEEK; n_ascii = 1'b0; n_cmt = 1'b0; n_acc = '0; n_w = '0;
                n_h = '0; n_max = '0; n_col = '0; n_row = '0; n_ci = '0;
                n_hi = '0; n_red = '0; n_grn = '0;
            end
        end else if (w_acc_in) begin
            n_out = '0;
            n_out.result_kind = KIND_ERROR;
            if (s_axis_tuser) begin
                if (r_ph == PH_TXT_NUM && r_ci >= 2'd2 && w_lastpos) begin
                    w_req.start = 1'b1; n_busy = 1'b1; n_eos = 1'b1;
                end else begin
                    if (r_ph != PH_SEEK && r_ph != PH_DONE && r_ph != PH_ERR) begin
                        n_out.error_code = ERR_TRUNC; n_ov = 1'b1;
                    end
                    n_ph = PH_SEEK; n_ascii = 1'b0; n_cmt = 1'b0; n_acc = '0; n_w = '0;
                    n_h = '0; n_max = '0; n_col = '0; n_row = '0; n_ci = '0;
                    n_hi = '0; n_red = '0; n_grn = '0;
                end
            end else begin
                unique case (r_ph)
                    PH_SEEK: begin
                        if (c != CH_P) begin
                            n_out.error_code = ERR_MAGIC; n_ov = 1'b1; n_ph = PH_ERR;
                        end else n_ph = PH_MAGIC;
                    end
                    PH_MAGIC: begin
                        if (c == CH_6 || c == CH_3) begin
                            n_ascii = (c == CH_3); n_cmt = 1'b0; n_ph = PH_SKIP_W;
                        end else begin
                            n_out.error_code = ERR_MAGIC; n_ov = 1'b1; n_ph = PH_ERR;
                        end
                    end
                    PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
                        if (r_cmt) begin
                            if (c == CH_LF) n_cmt = 1'b0;
                        end else if (is_space(c)) begin
                        end else if (c == CH_HASH) n_cmt = 1'b1;
                        else if (!is_digit(c)) begin
                            n_out.error_code = ERR_NUMBER; n_ov = 1'b1; n_ph = PH_ERR;
                        end else begin
                            n_acc = {9'd0, c - CH_0};
                            n_ph = (r_ph == PH_SKIP_W) ? PH_NUM_W :
                                   (r_ph == PH_SKIP_H) ? PH_NUM_H : PH_NUM_M;
                        end
                    end
                    PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
                        if (is_digit(c)) begin
                            n_acc = (w_mul > 21'(ACC_SAT)) ? ACC_SAT : w_mul[16:0];
                        end else if (!is_space(c) && c != CH_HASH) begin
                            n_out.error_code = ERR_NUMBER; n_ov = 1'b1; n_ph = PH_ERR;
                        end else if (r_ph != PH_NUM_M) begin
                            if (r_acc == '0) begin
                                n_out.error_code = ERR_SIZE; n_ov = 1'b1; n_ph = PH_ERR;
                            end else if (r_acc > SIDE_LIM || r_acc > {2'b0, SIDE_CAP}) begin
                                n_out.error_code = ERR_TOOLARGE; n_ov = 1'b1; n_ph = PH_ERR;
                            end else begin
                                if (r_ph == PH_NUM_W) begin
                                    n_w = r_acc[14:0]; n_ph = PH_SKIP_H;
                                end else begin
                                    n_h = r_acc[14:0]; n_ph = PH_SKIP_M;
                                end
                                n_cmt = (c == CH_HASH);
                            end
                        end else if (c == CH_HASH) begin
                            n_out.error_code = ERR_NUMBER; n_ov = 1'b1; n_ph = PH_ERR;
                        end else if (r_acc == '0 || r_acc > SAMP_LIM) begin
                            n_out.error_code = ERR_MAXVAL; n_ov = 1'b1; n_ph = PH_ERR;
                        end else begin
                            n_max = r_acc[15:0]; n_col = '0; n_row = '0; n_ci = '0;
                            n_cmt = 1'b0;
                            n_ph = r_ascii ? PH_TXT_SKP : PH_BIN_HI;
                            n_out = '0;
                            n_out.result_kind = KIND_HEADER;
                            n_out.width_out = r_w; n_out.height_out = r_h;
                            n_ov = 1'b1;
                        end
                    end
                    PH_BIN_HI: begin
                        if (r_max < 16'd256) begin
                            w_req.start = 1'b1; n_busy = 1'b1;
                        end else begin
                            n_hi = c; n_ph = PH_BIN_LO;
                        end
                    end
                    PH_BIN_LO: begin
                        n_ph = PH_BIN_HI; w_req.start = 1'b1; n_busy = 1'b1;
                    end
                    PH_TXT_SKP: begin
                        if (is_space(c)) begin
                        end else if (!is_digit(c)) begin
                            n_out.error_code = ERR_NUMBER; n_ov = 1'b1; n_ph = PH_ERR;
                        end else begin
                            n_acc = {9'd0, c - CH_0}; n_ph = PH_TXT_NUM;
                        end
                    end
                    PH_TXT_NUM: begin
                        if (is_digit(c)) begin
                            n_acc = (w_mul > 21'(ACC_SAT)) ? ACC_SAT : w_mul[16:0];
                        end else if (!is_space(c)) begin
                            n_out.error_code = ERR_NUMBER; n_ov = 1'b1; n_ph = PH_ERR;
                        end else begin
                            n_ph = PH_TXT_SKP; w_req.start = 1'b1; n_busy = 1'b1;
                        end
                    end
                    PH_DONE, PH_ERR: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (!n_ov) n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_SEEK; r_ascii <= 1'b0; r_cmt <= 1'b0; r_acc <= '0;
            r_w <= '0; r_h <= '0; r_max <= '0; r_col <= '0; r_row <= '0;
            r_ci <= '0; r_hi <= '0; r_red <= '0; r_grn <= '0;
            r_busy <= 1'b0; r_eos <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_ph <= n_ph; r_ascii <= n_ascii; r_cmt <= n_cmt; r_acc <= n_acc;
            r_w <= n_w; r_h <= n_h; r_max <= n_max; r_col <= n_col; r_row <= n_row;
            r_ci <= n_ci; r_hi <= n_hi; r_red <= n_red; r_grn <= n_grn;
            r_busy <= n_busy; r_eos <= n_eos; r_ov <= n_ov;
        end
        r_out <= n_out;
    end

    `PSD_ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, r_busy, !s_axis_tready,
        "input taken while dividing")
    `PSD_ASSERT_IMPL(a_done_busy, i_clk, i_rst_n, w_rsp.done, r_busy,
        "divider done while idle")
    `PSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && !m_axis_tready,
        r_ov && $stable(r_out), "output word lost")
endmodule
`default_nettype wire

[tb/sv/ppm_stream_decoder_unit_tb.sv]
`timescale 1ns / 1ps
module ppm_stream_decoder_unit_tb;
    import psd_pkg::*;

    // decoder parse phases
    typedef enum logic [3:0] {
        PH_SEEK, PH_MAGIC, PH_SKIP_W, PH_NUM_W, PH_SKIP_H, PH_NUM_H, PH_SKIP_M,
        PH_NUM_M, PH_BIN_HI, PH_BIN_LO, PH_TXT_SKP, PH_TXT_NUM, PH_DONE, PH_ERR
    } t_phase;

    typedef struct packed {
        logic       eos;
        logic [7:0] data;
    } t_word;

    // directed row: the expected result is typed in only where has_exp is set
    typedef struct packed {
        logic       eos;
        logic [7:0] data;
        logic       has_exp;
        t_result    exp;
    } t_row;

    localparam int  STALL_CYCLES = 600;
    localparam int  WATCHDOG     = 5000;
    localparam int  DRAIN_CYCLES = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tuser;   // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // result fields, result_kind lowest

    ppm_stream_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // decoder state
    t_phase      phase;
    logic        ascii_fmt;
    logic        in_comment;
    logic [16:0] acc;
    logic [14:0] img_w;
    logic [14:0] img_h;
    logic [15:0] maxval;
    logic [14:0] col;
    logic [14:0] row;
    logic [1:0]  comp;
    logic [7:0]  hi_hold;
    logic [7:0]  red_hold;
    logic [7:0]  green_hold;

    t_result     expected_results[$];
    t_word       stim_words[$];
    int          fail_count;
    int          recv_idle_pct;
    logic        recv_hold;

    function automatic logic ws(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic dig(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    task automatic clear_decoder();
        phase = PH_SEEK; ascii_fmt = 0; in_comment = 0; acc = 0; img_w = 0;
        img_h = 0; maxval = 0; col = 0; row = 0; comp = 0; hi_hold = 0;
        red_hold = 0; green_hold = 0;
    endtask

    function automatic logic [7:0] scale_sample(input logic [31:0] v);
        logic [31:0] m;
        logic [31:0] s;
        m = (maxval == 0) ? 32'd1 : {16'd0, maxval};
        s = (v * 255 + m / 2) / m;
        return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    task automatic push_error(input logic [2:0] code);
        t_result r;
        r = '0;
        r.result_kind = KIND_ERROR;
        r.error_code = code;
        expected_results.push_back(r);
        phase = PH_ERR;
    endtask

    task automatic accum_digit(input logic [7:0] c);
        logic [31:0] v;
        v = {15'd0, acc} * 10 + (c - 8'd48);
        acc = (v > 65536) ? ACC_SAT : v[16:0];
    endtask

    task automatic take_sample(input logic [31:0] raw);
        logic [7:0] s;
        logic       last;
        t_result    r;
        s = scale_sample(raw);
        if (comp == 0) begin
            red_hold = s; comp = 1;
        end else if (comp == 1) begin
            green_hold = s; comp = 2;
        end else begin
            comp = 0;
            last = ({17'd0, col} + 1 >= {17'd0, img_w}) &&
                   ({17'd0, row} + 1 >= {17'd0, img_h});
            r = '0;
            r.result_kind = KIND_PIXEL;
            r.red = red_hold; r.green = green_hold; r.blue = s;
            r.last_pixel = last;
            expected_results.push_back(r);
            if ({17'd0, col} + 1 >= {17'd0, img_w}) begin
                col = 0; row = row + 1;
            end else begin
                col = col + 1;
            end
            if (last) phase = PH_DONE;
        end
    endtask

    task automatic finish_side(input logic [7:0] c, input logic is_h);
        if (acc == 0) push_error(ERR_SIZE);
        else if (acc > 17'd32767) push_error(ERR_TOOLARGE);
        else begin
            if (is_h) begin
                img_h = acc[14:0]; phase = PH_SKIP_M;
            end else begin
                img_w = acc[14:0]; phase = PH_SKIP_H;
            end
            in_comment = (c == CH_HASH);
        end
    endtask

    task automatic finish_maxval(input logic [7:0] c);
        t_result r;
        if (c == CH_HASH) push_error(ERR_NUMBER);
        else if (acc == 0 || acc > 17'd65535) push_error(ERR_MAXVAL);
        else begin
            maxval = acc[15:0]; col = 0; row = 0; comp = 0; in_comment = 0;
            phase = ascii_fmt ? PH_TXT_SKP : PH_BIN_HI;
            r = '0;
            r.result_kind = KIND_HEADER;
            r.width_out = img_w; r.height_out = img_h;
            expected_results.push_back(r);
        end
    endtask

    task automatic predict_word(input t_word w);
        logic [7:0] c;
        c = w.data;
        if (w.eos) begin
            if (phase == PH_TXT_NUM && comp >= 2 &&
                {17'd0, col} + 1 >= {17'd0, img_w} &&
                {17'd0, row} + 1 >= {17'd0, img_h}) begin
                comp = 2;
                take_sample({15'd0, acc});
            end else if (phase != PH_SEEK && phase < PH_DONE) begin
                push_error(ERR_TRUNC);
            end
            clear_decoder();
            return;
        end
        case (phase)
            PH_SEEK: if (c != CH_P) push_error(ERR_MAGIC); else phase = PH_MAGIC;
            PH_MAGIC: begin
                if (c == CH_6 || c == CH_3) begin
                    ascii_fmt = (c == CH_3); in_comment = 0; phase = PH_SKIP_W;
                end else push_error(ERR_MAGIC);
            end
            PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
                if (in_comment) begin
                    if (c == CH_LF) in_comment = 0;
                end else if (ws(c)) begin
                end else if (c == CH_HASH) in_comment = 1;
                else if (!dig(c)) push_error(ERR_NUMBER);
                else begin
                    acc = c - CH_0; phase = t_phase'(phase + 1);
                end
            end
            PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
                if (dig(c)) accum_digit(c);
                else if (!ws(c) && c != CH_HASH) push_error(ERR_NUMBER);
                else if (phase == PH_NUM_W) finish_side(c, 1'b0);
                else if (phase == PH_NUM_H) finish_side(c, 1'b1);
                else finish_maxval(c);
            end
            PH_BIN_HI: begin
                if (maxval < 256) take_sample({24'd0, c});
                else begin
                    hi_hold = c; phase = PH_BIN_LO;
                end
            end
            PH_BIN_LO: begin
                phase = PH_BIN_HI;
                take_sample({16'd0, hi_hold, c});
            end
            PH_TXT_SKP: begin
                if (ws(c)) begin
                end else if (!dig(c)) push_error(ERR_NUMBER);
                else begin
                    acc = c - CH_0; phase = PH_TXT_NUM;
                end
            end
            PH_TXT_NUM: begin
                if (dig(c)) accum_digit(c);
                else if (!ws(c)) push_error(ERR_NUMBER);
                else begin
                    phase = PH_TXT_SKP; take_sample({15'd0, acc});
                end
            end
            default: ;
        endcase
    endtask

    // stimulus builders
    task automatic put_byte(input logic [7:0] b);
        stim_words.push_back('{eos: 1'b0, data: b});
    endtask

    task automatic put_eos();
        stim_words.push_back('{eos: 1'b1, data: 8'($urandom_range(0, 255))});
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_sep();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) put_str("\t");
        else if (k == 1) put_str("\r\n");
        else if (k == 2) put_str(" # note\n");
        else if (k == 3) put_str("\v\f");
        else put_str(" ");
    endtask

    task automatic put_image();
        int w;
        int h;
        int mv;
        logic txt;
        int  v;
        w = $urandom_range(1, 3);
        h = $urandom_range(1, 2);
        txt = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0: mv = 255;
            1: mv = $urandom_range(1, 255);
            2: mv = $urandom_range(256, 65535);
            default: mv = 65535;
        endcase
        put_str(txt ? "P3" : "P6");
        put_sep(); put_str($sformatf("%0d", w));
        put_sep(); put_str($sformatf("%0d", h));
        put_sep(); put_str($sformatf("%0d", mv));
        put_byte(txt ? 8'h0a : 8'($urandom_range(9, 13)));
        for (int i = 0; i < 3 * w * h; i++) begin
            // samples may exceed maxval to reach saturation
            v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, mv);
            if (txt) begin
                put_str($sformatf("%0d", v));
                if (i != 3 * w * h - 1 || $urandom_range(0, 1)) put_sep();
            end else if (mv < 256) put_byte(v[7:0]);
            else begin
                put_byte(v[15:8]); put_byte(v[7:0]);
            end
        end
        // sometimes trailing junk or a truncation
        if ($urandom_range(0, 5) == 0) put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) begin
            void'(stim_words.pop_back());
        end
        put_eos();
    endtask

    task automatic put_noise();
        int n;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 1)) put_str("P6 ");
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
        put_eos();
    endtask

    // sender
    task automatic send_word(input t_word w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w.data;
        s_axis_tuser  <= w.eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_word(w);
    endtask

    task automatic send_all(input int pct);
        t_word w;
        while (stim_words.size() > 0) begin
            w = stim_words.pop_front();
            while ($urandom_range(1, 100) <= pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            send_word(w);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
    endtask

    // receiver and checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= !recv_hold && ($urandom_range(1, 100) > recv_idle_pct);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result got;
            t_result want;
            got = t_result'(m_axis_tdata[59:0]);
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.result_kind !== want.result_kind) begin
                    $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
                    fail_count++;
                end
                if (got.red !== want.red) begin
                    $error("red exp %0d got %0d", want.red, got.red); fail_count++;
                end
                if (got.green !== want.green) begin
                    $error("green exp %0d got %0d", want.green, got.green); fail_count++;
                end
                if (got.blue !== want.blue) begin
                    $error("blue exp %0d got %0d", want.blue, got.blue); fail_count++;
                end
                if (got.width_out !== want.width_out) begin
                    $error("width_out exp %0d got %0d", want.width_out, got.width_out);
                    fail_count++;
                end
                if (got.height_out !== want.height_out) begin
                    $error("height_out exp %0d got %0d", want.height_out, got.height_out);
                    fail_count++;
                end
                if (got.last_pixel !== want.last_pixel) begin
                    $error("last_pixel exp %0d got %0d", want.last_pixel, got.last_pixel);
                    fail_count++;
                end
                if (got.error_code !== want.error_code) begin
                    $error("error_code exp %0d got %0d", want.error_code, got.error_code);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else if (i_rst_n) idle++;
            if (idle >= WATCHDOG) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // directed table: every row goes to the predictor, error rows also carry their code
    function automatic t_row row_b(input logic [7:0] b);
        return '{eos: 1'b0, data: b, has_exp: 1'b0, exp: '0};
    endfunction

    function automatic t_row row_eos();
        return '{eos: 1'b1, data: 8'h00, has_exp: 1'b0, exp: '0};
    endfunction

    function automatic t_row row_err(input logic e, input logic [7:0] b,
                                     input logic [2:0] code);
        t_result r;
        r = '0;
        r.result_kind = KIND_ERROR;
        r.error_code = code;
        return '{eos: e, data: b, has_exp: 1'b1, exp: r};
    endfunction

    initial begin
        t_row table_rows[$];
        string s;
        fail_count = 0;
        recv_idle_pct = 0;
        recv_hold = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_rst_n = 1'b0;
        clear_decoder();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // end of stream right after reset, bad magic, bad second byte
        table_rows.push_back(row_eos());
        table_rows.push_back(row_err(1'b0, 8'hff, ERR_MAGIC));
        table_rows.push_back(row_b(8'h00));
        table_rows.push_back(row_eos());
        table_rows.push_back(row_b(CH_P));
        table_rows.push_back(row_err(1'b0, 8'h35, ERR_MAGIC));
        table_rows.push_back(row_eos());
        // zero width, then truncated header
        s = "P60 ";
        foreach (s[i]) table_rows.push_back(row_b(s[i]));
        table_rows.push_back(row_eos());
        s = "P3 1";
        foreach (s[i]) table_rows.push_back(row_b(s[i]));
        table_rows.push_back(row_err(1'b1, 8'h00, ERR_TRUNC));
        foreach (table_rows[i]) begin
            predict_word('{eos: table_rows[i].eos, data: table_rows[i].data});
            if (table_rows[i].has_exp) begin
                void'(expected_results.pop_back());
                expected_results.push_back(table_rows[i].exp);
            end
            // predictor already applied above, so drive without a second prediction
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= table_rows[i].data;
            s_axis_tuser  <= table_rows[i].eos;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b0;

        // more special cases through the predictor
        put_str("P6 99999 "); put_eos();
        put_str("P6 1 1 0 "); put_eos();
        put_str("P6 1 1 70000 "); put_eos();
        put_str("P6 2x"); put_eos();
        put_str("P6 1 1 255#"); put_eos();
        put_str("P61\n#c\n1 255 "); put_byte(8'h00); put_byte(8'hff);
        put_byte(8'h80); put_byte(8'h01); put_eos();
        put_str("P3 1 1 10\n 0 20 5"); put_eos();
        put_str("P3 1 1 65535\n1234567 65535 0\n"); put_eos();
        put_str("P6 1 1 1000 "); put_byte(8'hff); put_byte(8'hff);
        put_eos();
        send_all(0);
        wait_drained();

        recv_idle_pct = 56;
        while (stim_words.size() < 400) begin
            if ($urandom_range(0, 5) == 0) put_noise(); else put_image();
        end
        send_all(32);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        recv_idle_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                repeat (STALL_CYCLES) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                while (stim_words.size() < 60) put_image();
                send_all(0);
            end
        join
        wait_drained();

        recv_idle_pct = 32;
        while (stim_words.size() < 400) begin
            if ($urandom_range(0, 5) == 0) put_noise(); else put_image();
        end
        send_all(56);
        wait_drained();

        recv_idle_pct = 0;
        while (stim_words.size() < 400) begin
            if ($urandom_range(0, 5) == 0) put_noise(); else put_image();
        end
        send_all(0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
